// ===== rtl/led_status_command_controller_assert.svh =====
// ---------------------------------------------------------------------------
// assertion macros for the led status command controller
// ---------------------------------------------------------------------------
`ifndef LED_STATUS_COMMAND_CONTROLLER_ASSERT_SVH
`define LED_STATUS_COMMAND_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define LSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lsc_pkg.sv =====
// ---------------------------------------------------------------------------
// lsc_pkg
// types, codes, keyword table and timing constants of the led status
// command controller
// ---------------------------------------------------------------------------
package lsc_pkg;

    // line buffer size and derived widths
    localparam int LINE_BYTES = 12;
    localparam int LEN_W      = $clog2(LINE_BYTES + 1);
    localparam int IDX_W      = $clog2(LINE_BYTES);

    // request kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // configuration register indexes (paddr[2])
    localparam logic REG_HEARTBEAT = 1'b0;

    // line terminator and text cut byte
    localparam logic [7:0] CHAR_END  = 8'h3B;
    localparam logic [7:0] CHAR_NULL = 8'h00;

    // drive levels
    localparam logic [7:0] LEVEL_ON  = 8'hFF;
    localparam logic [7:0] LEVEL_OFF = 8'h00;

    // timing constants in milliseconds
    localparam int BREATH_MS   = 4000;
    localparam int HALF_MS     = 2000;
    localparam int SLOW_MS     = 3000;
    localparam int QUICK_MS    = 1000;
    localparam int FRAME_MS    = 5000;
    localparam int OVERLAY_MS  = 4000;
    localparam int BLINK_ON_MS = 1000;
    localparam int SLOW_ON_MS  = 1500;
    localparam int QUICK_ON_MS = 500;

    // phase counter widths
    localparam int P4_W = $clog2(BREATH_MS);
    localparam int H_W  = $clog2(HALF_MS);
    localparam int P3_W = $clog2(SLOW_MS);
    localparam int P5_W = $clog2(FRAME_MS);
    localparam int SQ_W = 22;
    localparam int TO_W = 27;

    // breathing curve: (255*n + ROUND) / SQ_FULL via reciprocal of 15625
    localparam int SQ_FULL     = 4000000;
    localparam int SQ_ROUND    = 2000000;
    localparam int CURVE_W     = SQ_W + 8;
    localparam int RECIP_W     = 23;
    localparam int RECIP       = 4398047;
    localparam int RECIP_SHIFT = 36;
    localparam int PROD_W      = SQ_W + RECIP_W;

    typedef enum logic [1:0] {
        MODE_RED   = 2'd0,
        MODE_BLUE  = 2'd1,
        MODE_DEMO  = 2'd2,
        MODE_ERROR = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        PAT_BREATH = 3'd0,
        PAT_BLINK  = 3'd1,
        PAT_SLOW   = 3'd2,
        PAT_QUICK  = 3'd3,
        PAT_SOLID  = 3'd4,
        PAT_OFF    = 3'd5
    } t_pattern;

    typedef enum logic [1:0] {
        ACT_MODE    = 2'd0,
        ACT_PATTERN = 2'd1,
        ACT_BATTERY = 2'd2,
        ACT_HEART   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REPLY_NONE = 2'd0,
        REPLY_ACK  = 2'd1,
        REPLY_NAK  = 2'd2
    } t_reply;

    localparam logic [2:0] ARG_BATT_LOW  = 3'd1;
    localparam logic [2:0] ARG_BATT_GOOD = 3'd0;
    localparam logic [2:0] ARG_NONE      = 3'd0;

    // keyword table
    localparam int KW_COUNT = 11;
    localparam int KW_MAX   = 11;

    localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_COUNT] = '{
        88'("RedTeam"), 88'("BlueTeam"), 88'("Demo"), 88'("Disabled"),
        88'("Solid"), 88'("SlowBlink"), 88'("MediumBlink"), 88'("Off"),
        88'("LowBattery"), 88'("GoodBattery"), 88'("Heartbeat")
    };
    localparam int KW_LEN [KW_COUNT] = '{7, 8, 4, 8, 5, 9, 11, 3, 10, 11, 9};
    localparam t_action KW_ACT [KW_COUNT] = '{
        ACT_MODE, ACT_MODE, ACT_MODE, ACT_PATTERN, ACT_PATTERN, ACT_PATTERN,
        ACT_PATTERN, ACT_PATTERN, ACT_BATTERY, ACT_BATTERY, ACT_HEART
    };
    localparam logic [2:0] KW_ARG [KW_COUNT] = '{
        3'(MODE_RED), 3'(MODE_BLUE), 3'(MODE_DEMO), PAT_BREATH, PAT_SOLID,
        PAT_SLOW, PAT_BLINK, PAT_OFF, ARG_BATT_LOW, ARG_BATT_GOOD, ARG_NONE
    };

    typedef struct packed {
        logic       req_type;
        logic [7:0] serial_byte;
    } t_req_item;

    typedef struct packed {
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
        logic [7:0] brightness;
        logic [1:0] reply_code;
    } t_res_item;

    // decoded command at the end of a line
    typedef struct packed {
        logic       line_end;
        logic       known;
        t_action    act;
        logic [2:0] arg;
    } t_line_cmd;

    // millisecond phases used by the patterns
    typedef struct packed {
        logic [P4_W-1:0] p4;
        logic [H_W-1:0]  h;
        logic [SQ_W-1:0] sq;
        logic [P3_W-1:0] p3;
        logic [P5_W-1:0] p5;
    } t_phase;

endpackage

// ===== rtl/lsc_line_buf.sv =====
// ---------------------------------------------------------------------------
// lsc_line_buf
// collects command bytes into a line and matches it against the keywords
// ---------------------------------------------------------------------------
module lsc_line_buf import lsc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_req_item i_item,
    output t_line_cmd o_cmd
);

    logic [7:0]       r_buf [LINE_BYTES];
    logic [LEN_W-1:0] r_len;
    logic             r_ovf;
    logic             is_byte;
    logic             is_end;
    logic             has_room;
    logic [KW_COUNT-1:0] hit;

    assign is_byte  = i_accept && (i_item.req_type == REQ_BYTE);
    assign is_end   = i_item.serial_byte == CHAR_END;
    assign has_room = r_len < LEN_W'(LINE_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_ovf <= 1'b0;
        end else if (is_byte) begin
            if (is_end) begin
                r_len <= '0;
                r_ovf <= 1'b0;
            end else if (has_room) begin
                r_len <= r_len + LEN_W'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // storage only, no reset
    always_ff @(posedge i_clk) begin
        if (is_byte && !is_end && has_room) begin
            r_buf[r_len[IDX_W-1:0]] <= i_item.serial_byte;
        end
    end

    // one comparator per keyword
    for (genvar k = 0; k < KW_COUNT; k++) begin : g_kw
        logic [KW_MAX-1:0] eq;
        logic              ends_here;

        for (genvar i = 0; i < KW_MAX; i++) begin : g_byte
            if (i < KW_LEN[k]) begin : g_cmp
                assign eq[i] = r_buf[i] == KW_TEXT[k][(KW_LEN[k]-1-i)*8 +: 8];
            end else begin : g_pad
                assign eq[i] = 1'b1;
            end
        end

        // line ends right after the text, or a null byte cuts it there
        if (KW_LEN[k] < LINE_BYTES) begin : g_cut
            assign ends_here = ((r_len == LEN_W'(KW_LEN[k])) && !r_ovf)
                || ((r_len > LEN_W'(KW_LEN[k])) && (r_buf[KW_LEN[k]] == CHAR_NULL));
        end else begin : g_full
            assign ends_here = (r_len == LEN_W'(KW_LEN[k])) && !r_ovf;
        end

        assign hit[k] = (&eq) && ends_here;
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.line_end = (i_item.req_type == REQ_BYTE) && is_end;
        o_cmd.act      = ACT_MODE;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (hit[k]) begin
                o_cmd.known = 1'b1;
                o_cmd.act   = KW_ACT[k];
                o_cmd.arg   = KW_ARG[k];
            end
        end
    end

endmodule

// ===== rtl/lsc_timebase.sv =====
// ---------------------------------------------------------------------------
// lsc_timebase
// millisecond counter, pattern phases and heartbeat timeout
// ---------------------------------------------------------------------------
module lsc_timebase import lsc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tick,
    input  logic            i_hb_hit,
    input  logic [TO_W-1:0] i_timeout,
    output t_phase          o_phase,
    output logic            o_timed_out
);

    logic [31:0] r_ms;
    logic [31:0] r_last;
    t_phase      r_ph;
    t_phase      n_ph;
    logic [31:0] n_ms;
    logic [31:0] n_last;
    logic [31:0] age;

    always_comb begin
        n_ph = r_ph;
        if (i_tick) begin
            if (&r_ms) begin
                // counter wraps: every residue restarts
                n_ph = '0;
            end else begin
                n_ph.p4 = (r_ph.p4 == P4_W'(BREATH_MS - 1)) ? '0 : r_ph.p4 + P4_W'(1);
                n_ph.p3 = (r_ph.p3 == P3_W'(SLOW_MS - 1)) ? '0 : r_ph.p3 + P3_W'(1);
                n_ph.p5 = (r_ph.p5 == P5_W'(FRAME_MS - 1)) ? '0 : r_ph.p5 + P5_W'(1);
                if (r_ph.h == H_W'(HALF_MS - 1)) begin
                    n_ph.h  = '0;
                    n_ph.sq = '0;
                end else begin
                    // (h+1)^2 = h^2 + 2h + 1
                    n_ph.h  = r_ph.h + H_W'(1);
                    n_ph.sq = r_ph.sq + SQ_W'({r_ph.h, 1'b1});
                end
            end
        end
    end

    assign n_ms        = i_tick ? r_ms + 32'd1 : r_ms;
    assign n_last      = i_hb_hit ? r_ms : r_last;
    assign age         = n_ms - n_last;
    assign o_timed_out = age > 32'(i_timeout);
    assign o_phase     = r_ph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms   <= '0;
            r_last <= '0;
            r_ph   <= '0;
        end else begin
            r_ms   <= n_ms;
            r_last <= n_last;
            r_ph   <= n_ph;
        end
    end

endmodule

// ===== rtl/lsc_result.sv =====
// ---------------------------------------------------------------------------
// lsc_result
// forms colour, brightness and reply into the output register
// ---------------------------------------------------------------------------
module lsc_result import lsc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_pend,
    input  logic      i_out_stall,
    input  t_mode     i_shown,
    input  t_pattern  i_pattern,
    input  logic      i_battery,
    input  t_reply    i_reply,
    input  t_phase    i_phase,
    output logic      o_load,
    output logic      o_out_valid,
    output t_res_item o_out_item
);

    logic                r_valid;
    t_res_item           r_item;
    t_res_item           n_item;
    logic [SQ_W-1:0]     level;
    logic [CURVE_W-1:0]  scaled;
    logic [PROD_W-1:0]   prod;
    logic [7:0]          breath;
    logic [H_W-1:0]      quick_ph;

    assign o_load = i_pend && (!r_valid || !i_out_stall);

    // breathing: (255*n + 2000000) / 4000000, rounded half up
    assign level  = (i_phase.p4 <= P4_W'(HALF_MS)) ? i_phase.sq
                                                   : SQ_W'(SQ_FULL) - i_phase.sq;
    assign scaled = {level, 8'h00} - CURVE_W'(level) + CURVE_W'(SQ_ROUND);
    assign prod   = PROD_W'(scaled[CURVE_W-1:8]) * PROD_W'(RECIP);
    assign breath = prod[RECIP_SHIFT +: 8];

    assign quick_ph = (i_phase.h >= H_W'(QUICK_MS)) ? i_phase.h - H_W'(QUICK_MS)
                                                    : i_phase.h;

    always_comb begin
        n_item            = '0;
        n_item.reply_code = i_reply;
        unique case (i_shown)
            MODE_RED: begin
                n_item.red_level = LEVEL_ON;
            end
            MODE_BLUE: begin
                n_item.blue_level = LEVEL_ON;
            end
            MODE_DEMO: begin
                n_item.green_level = LEVEL_ON;
            end
            MODE_ERROR: begin
                n_item.red_level   = LEVEL_ON;
                n_item.green_level = LEVEL_ON;
            end
        endcase
        // low battery: yellow in the last second of each frame
        if (i_battery && (i_phase.p5 > P5_W'(OVERLAY_MS))) begin
            n_item.red_level   = LEVEL_ON;
            n_item.green_level = LEVEL_ON;
            n_item.blue_level  = LEVEL_OFF;
        end
        unique case (i_pattern)
            PAT_BREATH: n_item.brightness = breath;
            PAT_BLINK:  n_item.brightness = (i_phase.h <= H_W'(BLINK_ON_MS)) ?
                                            LEVEL_ON : LEVEL_OFF;
            PAT_SLOW:   n_item.brightness = (i_phase.p3 <= P3_W'(SLOW_ON_MS)) ?
                                            LEVEL_ON : LEVEL_OFF;
            PAT_SOLID:  n_item.brightness = LEVEL_ON;
            PAT_OFF:    n_item.brightness = LEVEL_OFF;
            default:    n_item.brightness = (quick_ph <= H_W'(QUICK_ON_MS)) ?
                                            LEVEL_ON : LEVEL_OFF;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_item <= n_item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

// ===== rtl/led_status_command_controller.sv =====
// ---------------------------------------------------------------------------
// led_status_command_controller
// serial command line decoder and led colour / brightness pattern generator
// ---------------------------------------------------------------------------
// usage
//   input channel: one transaction is either a received serial byte or a
//   one-millisecond tick. bytes build a line up to ';', which is matched
//   against the keyword set and updates mode, pattern or battery flag, or
//   refreshes the heartbeat.
//   output channel: exactly one result transaction per input transaction,
//   carrying rgb drive, pattern brightness and a reply code.
//   apb port: register 0 at byte address 0 is the heartbeat period in
//   seconds; the timeout is twice this in milliseconds.
// timing
//   state is updated at the accepting edge, the result register is loaded
//   from that state once it is free, and o_out_valid rises with that load.
//   one transaction per cycle sustained while the receiver does not stall;
//   the keyword compare and the breathing reciprocal multiplier are combinational.
// reset and stall
//   reset gives demo mode, breathing pattern, battery good, counters zero.
//   while the receiver stalls a held result, one further transaction may be
//   accepted and parked; after that o_in_stall rises until the result moves.
// ---------------------------------------------------------------------------
`include "led_status_command_controller_assert.svh"

module led_status_command_controller import lsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_req_item   i_in_item,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_res_item   o_out_item,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration
    logic [15:0]     r_hb_sec;
    logic [TO_W-1:0] r_timeout;
    logic            cfg_wr;

    // command state
    t_mode      r_cmd_mode;
    t_mode      r_shown;
    t_pattern   r_pattern;
    logic       r_battery;
    t_reply     r_reply;
    logic       r_pend;
    t_mode      n_cmd_mode;
    t_mode      n_shown;
    t_pattern   n_pattern;
    logic       n_battery;
    t_reply     n_reply;

    logic       accept;
    logic       load;
    logic       tick;
    logic       hb_hit;
    logic       timed_out;
    t_line_cmd  cmd;
    t_phase     phase;

    // ---------------------------------------------------------------------
    // apb register: period kept along with the precomputed timeout in ms
    // ---------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_HEARTBEAT);
    assign prdata = (paddr[2] == REG_HEARTBEAT) ? {16'h0000, r_hb_sec} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hb_sec  <= 16'd1;
            r_timeout <= TO_W'(HALF_MS);
        end else if (cfg_wr) begin
            r_hb_sec  <= pwdata[15:0];
            // seconds * 2000 = s*2048 - s*32 - s*16
            r_timeout <= {pwdata[15:0], 11'h000} - TO_W'({pwdata[15:0], 5'h00})
                         - TO_W'({pwdata[15:0], 4'h0});
        end
    end

    // ---------------------------------------------------------------------
    // handshake: a transaction parks in the state registers until the
    // result stage takes it
    // ---------------------------------------------------------------------
    assign o_in_stall = r_pend && !load;
    assign accept     = i_in_valid && !o_in_stall;
    assign tick       = accept && (i_in_item.req_type == REQ_TICK);
    assign hb_hit     = accept && cmd.line_end && cmd.known && (cmd.act == ACT_HEART);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (accept) begin
            r_pend <= 1'b1;
        end else if (load) begin
            r_pend <= 1'b0;
        end
    end

    lsc_line_buf u_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_cmd    (cmd)
    );

    lsc_timebase u_time (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (tick),
        .i_hb_hit    (hb_hit),
        .i_timeout   (r_timeout),
        .o_phase     (phase),
        .o_timed_out (timed_out)
    );

    // ---------------------------------------------------------------------
    // command decode: apply a finished line, then the heartbeat timeout
    // ---------------------------------------------------------------------
    always_comb begin
        n_cmd_mode = r_cmd_mode;
        n_shown    = r_shown;
        n_pattern  = r_pattern;
        n_battery  = r_battery;
        n_reply    = REPLY_NONE;
        if (cmd.line_end) begin
            if (cmd.known) begin
                unique case (cmd.act)
                    ACT_MODE:    n_cmd_mode = t_mode'(cmd.arg[1:0]);
                    ACT_PATTERN: n_pattern  = t_pattern'(cmd.arg);
                    ACT_BATTERY: n_battery  = cmd.arg[0];
                    ACT_HEART:   n_reply    = REPLY_ACK;
                endcase
            end else begin
                // unknown, empty or overlong line
                n_cmd_mode = MODE_ERROR;
                n_pattern  = PAT_SOLID;
                n_reply    = REPLY_NAK;
            end
            n_shown = n_cmd_mode;
        end
        if (timed_out) begin
            n_shown = MODE_ERROR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_mode <= MODE_DEMO;
            r_shown    <= MODE_DEMO;
            r_pattern  <= PAT_BREATH;
            r_battery  <= 1'b0;
            r_reply    <= REPLY_NONE;
        end else if (accept) begin
            r_cmd_mode <= n_cmd_mode;
            r_shown    <= n_shown;
            r_pattern  <= n_pattern;
            r_battery  <= n_battery;
            r_reply    <= n_reply;
        end
    end

    // ---------------------------------------------------------------------
    // result stage with its own output register
    // ---------------------------------------------------------------------
    lsc_result u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pend      (r_pend),
        .i_out_stall (i_out_stall),
        .i_shown     (r_shown),
        .i_pattern   (r_pattern),
        .i_battery   (r_battery),
        .i_reply     (r_reply),
        .i_phase     (phase),
        .o_load      (load),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    `LSC_ASSERT_NEXT(a_accept_parks, i_clk, i_rst_n, accept, r_pend,
        "accepted transaction not parked for the result stage")

    `LSC_ASSERT_NEXT(a_pend_held, i_clk, i_rst_n,
        r_pend && o_out_valid && i_out_stall, r_pend,
        "parked transaction dropped while the output was stalled")

    `LSC_ASSERT_NEXT(a_timeout_error, i_clk, i_rst_n, accept && timed_out,
        r_shown == MODE_ERROR, "heartbeat timeout did not force error mode")

    `LSC_ASSERT_NEXT(a_unknown_line, i_clk, i_rst_n,
        accept && cmd.line_end && !cmd.known,
        (r_cmd_mode == MODE_ERROR) && (r_pattern == PAT_SOLID) && (r_reply == REPLY_NAK),
        "unknown line did not select error mode with solid pattern")

endmodule

// ===== dv/led_status_command_controller_test.sv =====
// ---------------------------------------------------------------------------
// led_status_command_controller_test
// Drives command bytes and millisecond ticks into the controller and checks
// every result transaction against a cycle-free behavioural predictor held
// in this module. The run covers empty, zero-cut, overlong and near-miss
// lines, all keywords, and heartbeat timeouts. Tick sweeps run under
// randomly chosen patterns and the rising part of the breathing curve. Heartbeat
// periods are changed over the apb port and read back, random idling is
// applied on both channels, and a long receiver hold fills the block.
// ---------------------------------------------------------------------------
module led_status_command_controller_test;
    import lsc_pkg::*;

    localparam int unsigned HOLD_CYCLES = 150;   // long receiver hold-off
    localparam int unsigned DRAIN_LIMIT = 5000;  // cycles allowed to drain
    localparam int unsigned SETTLE      = 6;     // result latency plus margin

    // -----------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // -----------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_req_item   i_in_item   = '0;
    logic        i_out_stall = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    t_res_item   o_out_item;
    logic [31:0] prdata;
    logic        pready;

    led_status_command_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial forever #5 i_clk = ~i_clk;

    // overall limit, far above the slowest correct run
    initial begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

    // -----------------------------------------------------------------------
    // predictor state: mirrors the controller after every accepted transaction
    // -----------------------------------------------------------------------
    logic [31:0] ms_count   = '0;
    logic [31:0] last_hb    = '0;
    logic [15:0] hb_seconds = 16'd1;
    logic [7:0]  line_buf [LINE_BYTES];
    int unsigned line_len   = 0;
    bit          line_ovf   = 1'b0;
    t_mode       cmd_mode   = MODE_DEMO;
    t_mode       shown_mode = MODE_DEMO;
    t_pattern    pat_sel    = PAT_BREATH;
    bit          batt_low   = 1'b0;

    // keyword set and what each one does
    string cmd_word [KW_COUNT] = '{
        "RedTeam", "BlueTeam", "Demo", "Disabled", "Solid", "SlowBlink",
        "MediumBlink", "Off", "LowBattery", "GoodBattery", "Heartbeat"
    };
    t_action cmd_action [KW_COUNT] = '{
        ACT_MODE, ACT_MODE, ACT_MODE, ACT_PATTERN, ACT_PATTERN, ACT_PATTERN,
        ACT_PATTERN, ACT_PATTERN, ACT_BATTERY, ACT_BATTERY, ACT_HEART
    };
    logic [2:0] cmd_arg [KW_COUNT] = '{
        3'(MODE_RED), 3'(MODE_BLUE), 3'(MODE_DEMO), 3'(PAT_BREATH),
        3'(PAT_SOLID), 3'(PAT_SLOW), 3'(PAT_BLINK), 3'(PAT_OFF),
        ARG_BATT_LOW, ARG_BATT_GOOD, ARG_NONE
    };

    // results still owed by the block, oldest first
    t_res_item expected_drive [$];

    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned timeouts_hit = 0;

    // idling and hold-off control shared with the channel processes
    bit          tx_idle_on    = 1'b1;
    bit          rx_idle_on    = 1'b1;
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;

    // -----------------------------------------------------------------------
    // prediction
    // -----------------------------------------------------------------------
    function automatic logic [7:0] blink_level(int unsigned period);
        return (ms_count % period) <= period / 2 ? LEVEL_ON : LEVEL_OFF;
    endfunction

    function automatic logic [7:0] pattern_level();
        longint unsigned m, h, n;
        m = ms_count;
        case (pat_sel)
            PAT_BREATH: begin
                // rising square curve for the first half, falling after
                h = m % HALF_MS;
                n = (m % BREATH_MS) <= HALF_MS ? h * h : SQ_FULL - h * h;
                return 8'((n * 255 + SQ_ROUND) / SQ_FULL);
            end
            PAT_BLINK: return blink_level(HALF_MS);
            PAT_SLOW:  return blink_level(SLOW_MS);
            PAT_SOLID: return LEVEL_ON;
            PAT_OFF:   return LEVEL_OFF;
            default:   return blink_level(QUICK_MS);  // quick and unused codes
        endcase
    endfunction

    // decode the collected line, update the command state, give the reply
    function automatic t_reply decode_line();
        int unsigned n;
        bit          cut, known, hit;
        t_reply      rep;
        n     = line_len;
        cut   = 1'b0;
        known = 1'b0;
        rep   = REPLY_NONE;
        // a zero byte ends the text and cancels any overflow
        for (int i = 0; i < line_len && i < LINE_BYTES; i++) begin
            if (!cut && line_buf[i] == CHAR_NULL) begin
                n   = i;
                cut = 1'b1;
            end
        end
        if (cut || !line_ovf) begin
            for (int k = 0; k < KW_COUNT; k++) begin
                hit = !known && cmd_word[k].len() == n;
                for (int i = 0; hit && i < n; i++)
                    if (line_buf[i] != cmd_word[k][i]) hit = 1'b0;
                if (hit) begin
                    known = 1'b1;
                    case (cmd_action[k])
                        ACT_MODE:    cmd_mode = t_mode'(cmd_arg[k][1:0]);
                        ACT_PATTERN: pat_sel  = t_pattern'(cmd_arg[k]);
                        ACT_BATTERY: batt_low = (cmd_arg[k] == ARG_BATT_LOW);
                        default: begin
                            last_hb = ms_count;
                            rep     = REPLY_ACK;
                        end
                    endcase
                end
            end
        end
        // unknown, empty or overlong line
        if (!known) begin
            cmd_mode = MODE_ERROR;
            pat_sel  = PAT_SOLID;
            rep      = REPLY_NAK;
        end
        shown_mode = cmd_mode;
        return rep;
    endfunction

    // advance the predictor by one transaction and return the expected drive
    function automatic t_res_item compute_drive(t_req_item it);
        t_res_item d;
        t_reply    rep;
        rep = REPLY_NONE;
        if (it.req_type == REQ_TICK) begin
            ms_count = ms_count + 32'd1;
        end else if (it.serial_byte == CHAR_END) begin
            rep      = decode_line();
            line_len = 0;
            line_ovf = 1'b0;
        end else if (line_len < LINE_BYTES) begin
            line_buf[line_len] = it.serial_byte;
            line_len++;
        end else begin
            line_ovf = 1'b1;
        end
        // heartbeat timeout, wrap-safe difference
        if (ms_count - last_hb > 32'(hb_seconds) * 32'd2000) begin
            if (shown_mode != MODE_ERROR) timeouts_hit++;
            shown_mode = MODE_ERROR;
        end
        case (shown_mode)
            MODE_RED:  {d.red_level, d.green_level, d.blue_level} =
                           {LEVEL_ON, LEVEL_OFF, LEVEL_OFF};
            MODE_BLUE: {d.red_level, d.green_level, d.blue_level} =
                           {LEVEL_OFF, LEVEL_OFF, LEVEL_ON};
            MODE_DEMO: {d.red_level, d.green_level, d.blue_level} =
                           {LEVEL_OFF, LEVEL_ON, LEVEL_OFF};
            default:   {d.red_level, d.green_level, d.blue_level} =
                           {LEVEL_ON, LEVEL_ON, LEVEL_OFF};
        endcase
        // low battery shows yellow in the last second of each 5 s frame
        if (batt_low && (ms_count % 32'(FRAME_MS)) > 32'(OVERLAY_MS))
            {d.red_level, d.green_level, d.blue_level} =
                {LEVEL_ON, LEVEL_ON, LEVEL_OFF};
        d.brightness = pattern_level();
        d.reply_code = rep;
        return d;
    endfunction

    // -----------------------------------------------------------------------
    // result checking: every accepted result against the oldest expectation
    // -----------------------------------------------------------------------
    t_res_item head_drive;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_drive.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: r=%0d g=%0d b=%0d br=%0d reply=%0d",
                             o_out_item.red_level, o_out_item.green_level,
                             o_out_item.blue_level, o_out_item.brightness,
                             o_out_item.reply_code);
            end else begin
                head_drive = expected_drive.pop_front();
                if (o_out_item.red_level   !== head_drive.red_level   ||
                    o_out_item.green_level !== head_drive.green_level ||
                    o_out_item.blue_level  !== head_drive.blue_level  ||
                    o_out_item.brightness  !== head_drive.brightness  ||
                    o_out_item.reply_code  !== head_drive.reply_code) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected r=%0d g=%0d b=%0d br=%0d reply=%0d, got r=%0d g=%0d b=%0d br=%0d reply=%0d",
                                 results_seen, head_drive.red_level,
                                 head_drive.green_level, head_drive.blue_level,
                                 head_drive.brightness, head_drive.reply_code,
                                 o_out_item.red_level, o_out_item.green_level,
                                 o_out_item.blue_level, o_out_item.brightness,
                                 o_out_item.reply_code);
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // receiver: random stall, or a long counted hold-off on request
    // -----------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_requests != hold_served) begin
                hold_served++;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_idle_on) begin
                i_out_stall <= ($urandom_range(0, 99) < 33);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // sender side: one transaction, with random idle cycles ahead of it
    // -----------------------------------------------------------------------
    task automatic send_item(t_req_item it);
        while (tx_idle_on && $urandom_range(0, 99) < 33) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // accepted at this edge; valid stays up only if another follows now
        expected_drive.push_back(compute_drive(it));
        items_sent++;
    endtask

    task automatic send_byte(logic [7:0] c);
        t_req_item it;
        it.req_type    = REQ_BYTE;
        it.serial_byte = c;
        send_item(it);
    endtask

    task automatic send_ticks(int unsigned count);
        t_req_item it;
        repeat (count) begin
            it.req_type    = REQ_TICK;
            it.serial_byte = 8'($urandom_range(0, 255));  // ignored on ticks
            send_item(it);
        end
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // any byte except the line terminator
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == CHAR_END) ? CHAR_NULL : b;
    endfunction

    // one command line: mostly keywords, the rest near misses and noise
    task automatic send_random_line();
        int unsigned kind, k, pos, len;
        string       word;
        kind = $urandom_range(0, 99);
        k    = $urandom_range(0, KW_COUNT - 1);
        word = cmd_word[k];
        if (kind < 60) begin
            send_text({word, ";"});
        end else if (kind < 68) begin
            // keyword with one character replaced
            pos = $urandom_range(0, word.len() - 1);
            for (int i = 0; i < word.len(); i++)
                send_byte(i == pos ? text_byte() : word[i]);
            send_byte(CHAR_END);
        end else if (kind < 76) begin
            // keyword cut by a zero byte, junk after it, sometimes overlong
            send_text(word);
            send_byte(CHAR_NULL);
            repeat ($urandom_range(0, 8)) send_byte(text_byte());
            send_byte(CHAR_END);
        end else if (kind < 84) begin
            // overlong line, sometimes starting with a keyword
            len = $urandom_range(LINE_BYTES + 1, LINE_BYTES + 8);
            if (kind < 80) begin
                send_text(word);
                len = len - word.len();
            end
            repeat (len) send_byte(text_byte() | 8'h01);
            send_byte(CHAR_END);
        end else if (kind < 92) begin
            // truncated keyword or keyword with a trailing character
            if (kind < 88) send_text(word.substr(0, word.len() - 2));
            else           send_text({word, "x"});
            send_byte(CHAR_END);
        end else begin
            // raw noise, terminators included, possibly an empty line
            repeat ($urandom_range(0, LINE_BYTES))
                send_byte(8'($urandom_range(0, 255)));
            send_byte(CHAR_END);
        end
    endtask

    // -----------------------------------------------------------------------
    // configuration port
    // -----------------------------------------------------------------------
    task automatic apb_access(logic wr, logic [31:0] data, output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_HEARTBEAT, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // let every owed result arrive, then let the pipeline settle
    task automatic wait_for_results();
        int unsigned guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (expected_drive.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // write the heartbeat period while idle and read it back
    task automatic set_heartbeat(logic [15:0] seconds);
        logic [31:0] rd;
        wait_for_results();
        apb_access(1'b1, {16'h0, seconds}, rd);
        hb_seconds = seconds;
        apb_access(1'b0, '0, rd);
        if (rd !== {16'h0, seconds}) begin
            mismatches++;
            if (mismatches <= 10)
                $display("heartbeat register: expected %0d, read %0d", seconds, rd);
        end
    endtask

    // -----------------------------------------------------------------------
    // tests
    // -----------------------------------------------------------------------
    task automatic apply_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    // field extremes and the line special cases
    task automatic test_directed_lines();
        send_ticks(1);
        send_byte(CHAR_END);                      // empty line is not understood
        send_text("Off");                         // zero byte ends the text
        send_byte(CHAR_NULL);
        send_byte(8'hFF);
        send_byte(CHAR_END);
        send_text("Demo");                        // zero cut beats an overflow
        send_byte(CHAR_NULL);
        repeat (9) send_byte(8'hFF);
        send_byte(CHAR_END);
    endtask

    // command lines separated by short bursts of ticks
    task automatic test_random_commands(int unsigned count);
        int unsigned stop;
        stop = items_sent + count;
        while (items_sent < stop) begin
            send_ticks($urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 8));
            send_random_line();
        end
    endtask

    // tick runs under each selected pattern and battery state
    task automatic test_pattern_sweep(int unsigned segments);
        string word;
        for (int s = 0; s < segments; s++) begin
            if (s % 4 == 0) begin
                if ($urandom_range(0, 2) != 0) word = "LowBattery";
                else                           word = "GoodBattery";
            end else begin
                word = cmd_word[$urandom_range(0, KW_COUNT - 1)];
            end
            send_text({word, ";"});
            send_ticks(120);
        end
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_back_pressure();
        int unsigned stop;
        wait_for_results();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_requests++;
        stop = items_sent + 40;
        while (items_sent < stop) begin
            send_ticks($urandom_range(0, 4));
            send_random_line();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // -----------------------------------------------------------------------
    // sequence of tests
    // -----------------------------------------------------------------------
    initial begin
        for (int i = 0; i < LINE_BYTES; i++) line_buf[i] = '0;
        apply_reset();

        set_heartbeat(16'd1);
        test_directed_lines();

        set_heartbeat(16'hFFFF);
        test_random_commands(220);
        // zero period: any tick after a heartbeat times out
        set_heartbeat(16'd0);
        test_random_commands(100);

        // first sweep half without idling on either side
        set_heartbeat(16'd1);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_pattern_sweep(3);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        set_heartbeat(16'd2);
        test_pattern_sweep(3);

        test_back_pressure();

        wait_for_results();
        if (expected_drive.size() != 0) begin
            mismatches += expected_drive.size();
            $display("%0d result transactions never arrived", expected_drive.size());
        end
        $display("run covered %0d transactions and %0d results over %0d simulated ms",
                 items_sent, results_seen, ms_count);
        $display("lines: keywords, near misses, zero-cut, overlong, empty; %0d heartbeat timeouts",
                 timeouts_hit);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
